[hw/rtl/assert_macros.svh]
// Assertion helpers shared by dcb_queue and dcb_back.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every clock edge outside reset
`define DCB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// cond must never be true outside reset
`define DCB_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define DCB_ASSERT(lbl, clk, rst_n, prop, msg)

`define DCB_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

[hw/rtl/dcb_pkg.sv]
package dcb_pkg;

    localparam int RAW_W      = 16;
    localparam int SAMPLE_W   = 12;
    localparam int EST_W      = 28;
    localparam int COEFF_W    = 16;
    localparam int OUT_W      = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [EST_W-1:0]     EST_RESET   = 28'd134217728;  // 2048.0 in Q12.16
    localparam logic [COEFF_W-1:0]   COEFF_RESET = 16'd33;

    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SWAP      = 8'd1;

    typedef struct packed {
        logic [COEFF_W-1:0] coeff;
        logic               swap;
    } dcb_cfg_t;

    // One queue entry: one result, or two when a held pair is released.
    typedef struct packed {
        logic [OUT_W-1:0] first;
        logic [OUT_W-1:0] second;
        logic             two;
        logic             eob;
    } dcb_job_t;

endpackage

[hw/rtl/dcb_if.sv]
interface dcb_in_if import dcb_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [RAW_W-1:0] raw_word;
    logic             end_of_buffer;

    modport source (output valid, output raw_word, output end_of_buffer, input ready);
    modport sink   (input valid, input raw_word, input end_of_buffer, output ready);
endinterface

interface dcb_out_if import dcb_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] sample;
    logic                    last_of_run;
    logic                    buffer_done;

    modport source (output valid, output sample, output last_of_run, output buffer_done,
                    input ready);
    modport sink   (input valid, input sample, input last_of_run, input buffer_done,
                    output ready);
endinterface

interface dcb_cfg_if import dcb_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/dcb_front.sv]
module dcb_front import dcb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  dcb_cfg_t cfg_q,
    dcb_in_if.sink   in_ch,
    output logic     job_valid,
    output dcb_job_t job,
    input  logic     job_ready
);

    logic [EST_W-1:0]    est_reg;
    logic [EST_W-1:0]    est_next;
    logic                a_valid_reg;
    logic                a_valid_next;
    logic [SAMPLE_W-1:0] a_x_reg;
    logic                a_eob_reg;
    logic [OUT_W-1:0]    held_reg;
    logic                odd_reg;

    logic                accept;
    logic                advance;
    logic                emit;

    logic [SAMPLE_W-1:0] x_in;
    logic signed [EST_W:0]      diff_in;
    logic signed [EST_W+17:0]   prod;
    logic signed [EST_W+17:0]   prod_adj;
    logic signed [EST_W+1:0]    delta;
    logic [EST_W+1:0]           est_sum;

    logic signed [EST_W:0]      diff_b;
    logic signed [EST_W:0]      diff_adj;
    logic signed [EST_W-12:0]   quot;
    logic [OUT_W-1:0]           s;

    // estimate update: est += trunc((target - est) * alpha / 65536)
    always_comb
    begin
        x_in     = in_ch.raw_word[SAMPLE_W-1:0];
        diff_in  = $signed({1'b0, x_in, 16'h0000}) - $signed({1'b0, est_reg});
        prod     = diff_in * $signed({1'b0, cfg_q.coeff});
        prod_adj = prod + (prod[EST_W+17] ? (EST_W+18)'(65535) : (EST_W+18)'(0));
        delta    = prod_adj[EST_W+17:16];
        est_sum  = {2'b00, est_reg} + delta;
        est_next = est_sum[EST_W-1:0];
    end

    // output value from the updated estimate: trunc(diff / 4096), saturated
    always_comb
    begin
        diff_b   = $signed({1'b0, a_x_reg, 16'h0000}) - $signed({1'b0, est_reg});
        diff_adj = diff_b + (diff_b[EST_W] ? (EST_W+1)'(4095) : (EST_W+1)'(0));
        quot     = diff_adj[EST_W:12];
        if (quot[EST_W-12] != quot[OUT_W-1])
            s = quot[EST_W-12] ? 16'h8000 : 16'h7FFF;
        else
            s = quot[OUT_W-1:0];
    end

    always_comb
    begin
        emit       = odd_reg || !(cfg_q.swap && !a_eob_reg);
        job.first  = s;
        job.second = odd_reg ? held_reg : s;
        job.two    = odd_reg;
        job.eob    = a_eob_reg;
        job_valid  = a_valid_reg && emit;
        advance    = a_valid_reg && (job_ready || !emit);
        in_ch.ready = !a_valid_reg || advance;
        accept     = in_ch.valid && in_ch.ready;
        if (accept)
            a_valid_next = 1'b1;
        else if (advance)
            a_valid_next = 1'b0;
        else
            a_valid_next = a_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            est_reg     <= EST_RESET;
            a_valid_reg <= 1'b0;
            held_reg    <= '0;
            odd_reg     <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            if (accept)
                est_reg <= est_next;
            if (advance)
            begin
                if (odd_reg)
                begin
                    odd_reg  <= 1'b0;
                    held_reg <= '0;
                end
                else if (cfg_q.swap && !a_eob_reg)
                begin
                    odd_reg  <= 1'b1;
                    held_reg <= s;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_x_reg   <= x_in;
            a_eob_reg <= in_ch.end_of_buffer;
        end
    end

endmodule

[hw/rtl/dcb_queue.sv]
`include "assert_macros.svh"

module dcb_queue import dcb_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push_valid,
    output logic     push_ready,
    input  dcb_job_t push_data,
    output logic     pop_valid,
    input  logic     pop_ready,
    output dcb_job_t pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    dcb_job_t         mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    always_comb
    begin
        push_ready = count_reg != CNT_W'(DEPTH);
        pop_valid  = count_reg != '0;
        push       = push_valid && push_ready;
        pop        = pop_valid && pop_ready;
        pop_data   = mem[rd_ptr_reg];
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    `DCB_ASSERT(a_count_bound, clk, rst_n, count_reg <= CNT_W'(DEPTH), "queue overfilled")
    `DCB_ASSERT(a_count_up, clk, rst_n, push && !pop |=> count_reg == $past(count_reg) + 1'b1, "queue count lost a push")
    `DCB_ASSERT(a_ptr_sync, clk, rst_n, (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg), "queue pointers out of step")

endmodule

[hw/rtl/dcb_back.sv]
`include "assert_macros.svh"

module dcb_back import dcb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     q_valid,
    output logic     q_ready,
    input  dcb_job_t q_data,
    dcb_out_if.source out_ch
);

    dcb_job_t job_reg;
    logic     job_valid_reg;
    logic     phase_reg;
    logic     xfer;
    logic     finish;
    logic     last;

    always_comb
    begin
        last               = !job_reg.two || phase_reg;
        out_ch.valid       = job_valid_reg;
        out_ch.sample      = phase_reg ? job_reg.second : job_reg.first;
        out_ch.last_of_run = last;
        out_ch.buffer_done = last && job_reg.eob;
        xfer               = job_valid_reg && out_ch.ready;
        finish             = xfer && last;
        q_ready            = !job_valid_reg || finish;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else if (q_valid && q_ready)
        begin
            job_valid_reg <= 1'b1;
            phase_reg     <= 1'b0;
        end
        else if (finish)
        begin
            job_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else if (xfer)
            phase_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (q_valid && q_ready)
            job_reg <= q_data;
    end

    `DCB_ASSERT_NEVER(a_phase_single, clk, rst_n, phase_reg && !job_reg.two, "second phase on a single job")
    `DCB_ASSERT_NEVER(a_phase_idle, clk, rst_n, phase_reg && !job_valid_reg, "second phase with no job")
    `DCB_ASSERT(a_pair_order, clk, rst_n, xfer && !last |=> job_valid_reg && phase_reg, "pair not completed in order")

endmodule

[hw/rtl/adc_dc_blocking_conditioner_unit.sv]
// DC-blocking conditioner for raw ADC words.
// in_ch  : raw_word (low 12 bits are the sample) and end_of_buffer, valid/ready.
// out_ch : signed sample (x - dc) * 16 saturated to 16 bits, last_of_run marks
//          the final result of an input word, buffer_done the last of a buffer.
// cfg    : index 0 writes the Q0.16 smoothing coefficient, index 1 the pair-swap
//          enable; writes are always accepted, other indexes are dropped.
// Throughput: one input word per cycle while the queue takes results; the
// estimate update (one 29x17 multiply and add) is registered on the transfer.
// A result moves from the front stage via the queue to the output register.
// With swap on, an even word not ending a buffer gives no result; its odd
// partner then gives two, back to back. Results wait in a QUEUE_DEPTH-entry
// queue; when out_ch stalls the queue fills and in_ch.ready drops once it is
// full and the front stage is occupied. Reset: dc estimate 2048.0,
// coefficient 33, swap off, no held sample, all queued results dropped.
module adc_dc_blocking_conditioner_unit import dcb_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    dcb_in_if.sink    in_ch,
    dcb_out_if.source out_ch,
    dcb_cfg_if.sink   cfg
);

    logic [COEFF_W-1:0] coeff_reg;
    logic               swap_reg;
    dcb_cfg_t           cfg_q;

    logic     f_valid;
    logic     f_ready;
    dcb_job_t f_job;
    logic     b_valid;
    logic     b_ready;
    dcb_job_t b_job;

    assign cfg.ready   = 1'b1;
    assign cfg_q.coeff = coeff_reg;
    assign cfg_q.swap  = swap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_reg <= COEFF_RESET;
            swap_reg  <= 1'b0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_SMOOTHING: coeff_reg <= cfg.data[COEFF_W-1:0];
                CFG_SWAP:      swap_reg  <= cfg.data[0];
                default:       ;
            endcase
        end
    end

    dcb_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_q     (cfg_q),
        .in_ch     (in_ch),
        .job_valid (f_valid),
        .job       (f_job),
        .job_ready (f_ready)
    );

    dcb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_job),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (b_job)
    );

    dcb_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (b_valid),
        .q_ready (b_ready),
        .q_data  (b_job),
        .out_ch  (out_ch)
    );

endmodule

[verif/tb_adc_dc_blocking_conditioner_unit.sv]
module tb_adc_dc_blocking_conditioner_unit;
    import dcb_pkg::*;

    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 300;
    localparam int MAX_REPORTS   = 10;
    localparam int RANDOM_WORDS  = 1200;

    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 8'hA5;
    localparam logic [COEFF_W-1:0]   COEFF_MIN    = 16'h0000;
    localparam logic [COEFF_W-1:0]   COEFF_MAX    = 16'hFFFF;

    typedef struct packed {
        logic [RAW_W-1:0] raw;
        logic             eob;
    } adc_word_t;

    typedef struct packed {
        logic [OUT_W-1:0] sample;
        logic             last;
        logic             done;
    } cond_result_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic [RAW_W-1:0] in_raw    = '0;
    logic             in_eob    = 1'b0;
    logic             out_ready = 1'b0;

    dcb_in_if  in_if ();
    dcb_out_if out_if ();
    dcb_cfg_if cfg_if ();

    assign in_if.valid         = in_valid;
    assign in_if.raw_word      = in_raw;
    assign in_if.end_of_buffer = in_eob;
    assign out_if.ready        = out_ready;

    adc_dc_blocking_conditioner_unit uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_if),
        .out_ch (out_if),
        .cfg    (cfg_if)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // predictor state
    logic [COEFF_W-1:0] model_coeff = COEFF_RESET;
    logic               model_swap  = 1'b0;
    logic [EST_W-1:0]   dc_est      = EST_RESET;
    logic [OUT_W-1:0]   held_sample = '0;
    logic               pair_open   = 1'b0;

    adc_word_t    words_to_send[$];
    cond_result_t due_samples[$];

    bit no_gaps        = 1'b0;
    int long_hold_req  = 0;
    int long_hold_ack  = 0;
    int items_queued   = 0;
    int words_taken    = 0;
    int results_seen   = 0;
    int mismatches     = 0;
    int sat_hits       = 0;
    int swapped_pairs  = 0;
    int reg_writes     = 0;

    function automatic logic [OUT_W-1:0] remove_dc(input logic [SAMPLE_W-1:0] x);
        longint target;
        longint delta;
        longint est;
        longint q;
        target = longint'(x) * 65536;
        // SV signed division truncates toward zero, as the update requires
        delta = ((target - longint'(dc_est)) * longint'(model_coeff)) / 65536;
        est = longint'(dc_est) + delta;
        dc_est = est[EST_W-1:0];
        q = (target - longint'(dc_est)) / 4096;
        if (q > 32767)
        begin
            q = 32767;
            sat_hits++;
        end
        else if (q < -32768)
        begin
            q = -32768;
            sat_hits++;
        end
        return q[OUT_W-1:0];
    endfunction

    function automatic void condition_word(input logic [RAW_W-1:0] raw, input logic eob);
        logic [OUT_W-1:0] s;
        s = remove_dc(raw[SAMPLE_W-1:0]);
        if (pair_open)
        begin
            due_samples.push_back('{s, 1'b0, 1'b0});
            due_samples.push_back('{held_sample, 1'b1, eob});
            pair_open   = 1'b0;
            held_sample = '0;
            swapped_pairs++;
        end
        else if (model_swap && !eob)
        begin
            held_sample = s;
            pair_open   = 1'b1;
        end
        else
        begin
            due_samples.push_back('{s, 1'b1, eob});
        end
    endfunction

    function automatic void check_result(input cond_result_t got);
        cond_result_t want;
        results_seen++;
        if (due_samples.size() == 0)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("unexpected result: sample %0d last_of_run %b buffer_done %b",
                         $signed(got.sample), got.last, got.done);
        end
        else
        begin
            want = due_samples.pop_front();
            if (got.sample !== want.sample || got.last !== want.last
                || got.done !== want.done)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result %0d: sample exp %0d got %0d, last_of_run exp %b got %b, %s",
                             results_seen, $signed(want.sample), $signed(got.sample),
                             want.last, got.last,
                             $sformatf("buffer_done exp %b got %b", want.done, got.done));
            end
        end
    endfunction

    // input driver
    int        send_gap;
    adc_word_t next_word;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && in_if.ready)
            begin
                condition_word(in_raw, in_eob);
                words_taken++;
            end
            if (!in_valid || in_if.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (words_to_send.size() > 0)
                begin
                    next_word = words_to_send.pop_front();
                    in_valid  <= 1'b1;
                    in_raw    <= next_word.raw;
                    in_eob    <= next_word.eob;
                    send_gap  <= no_gaps ? 0 : $urandom_range(0, 9);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output monitor
    int take_gap;
    int hold_left;
    int gap_n;
    int hold_n;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            take_gap  <= 0;
            hold_left <= 0;
        end
        else
        begin
            gap_n  = take_gap;
            hold_n = hold_left;
            if (out_if.valid && out_ready)
            begin
                check_result('{out_if.sample, out_if.last_of_run, out_if.buffer_done});
                gap_n = no_gaps ? 0 : $urandom_range(0, 9);
            end
            if (long_hold_req != long_hold_ack)
            begin
                long_hold_ack <= long_hold_req;
                hold_n = LONG_HOLD;
            end
            if (hold_n > 0)
            begin
                hold_n--;
                out_ready <= 1'b0;
            end
            else if (gap_n > 0)
            begin
                gap_n--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
            take_gap  <= gap_n;
            hold_left <= hold_n;
        end
    end

    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_if.ready) || (out_if.valid && out_ready)
                || (cfg_if.valid && cfg_if.ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                         idle_cycles, due_samples.size());
                $display("CHECKS FAILED");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        if (idx == CFG_SMOOTHING)
            model_coeff = val[COEFF_W-1:0];
        else if (idx == CFG_SWAP)
            model_swap = val[0];
        reg_writes++;
    endtask

    task automatic queue_word(input logic [RAW_W-1:0] raw, input logic eob);
        words_to_send.push_back('{raw, eob});
        items_queued++;
    endtask

    // block is idle once every word is taken and every result is back
    task automatic settle();
        while (words_taken != items_queued)
            @(posedge clk);
        while (due_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [RAW_W-1:0] draw_raw();
        logic [RAW_W-1:0] r;
        r = RAW_W'($urandom);
        case ($urandom_range(0, 7))
            0: r[SAMPLE_W-1:0] = '0;
            1: r[SAMPLE_W-1:0] = '1;
            2: r[SAMPLE_W-1:0] = SAMPLE_W'(1000 + $urandom_range(0, 63));  // quiet signal on DC
            default: ;
        endcase
        return r;
    endfunction

    task automatic queue_buffers(input int n);
        int left_in_buf;
        logic eob;
        left_in_buf = $urandom_range(1, 12);
        for (int i = 0; i < n; i++)
        begin
            left_in_buf--;
            eob = (left_in_buf == 0) || (i == n - 1);
            if (eob)
                left_in_buf = $urandom_range(1, 12);
            queue_word(draw_raw(), eob);
        end
    endtask

    int target_items;

    initial
    begin
        cfg_if.valid = 1'b0;
        cfg_if.index = CFG_SMOOTHING;
        cfg_if.data  = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset settings, field extremes, channel nibble must be ignored
        queue_word(16'h0000, 1'b0);
        queue_word(16'hFFFF, 1'b0);
        queue_word(16'hF000, 1'b0);
        queue_word(16'h0FFF, 1'b0);
        queue_word(16'h8800, 1'b1);
        settle();

        // pull the estimate to zero, then freeze it and overdrive both ways
        write_reg(CFG_SMOOTHING, COEFF_MAX);
        queue_word(16'h0000, 1'b0);
        queue_word(16'h3000, 1'b0);
        queue_word(16'h0000, 1'b1);
        settle();
        write_reg(CFG_SMOOTHING, COEFF_MIN);
        queue_word(16'h0FFF, 1'b1);
        settle();
        write_reg(CFG_SMOOTHING, COEFF_MAX);
        queue_word(16'hAFFF, 1'b0);
        queue_word(16'hAFFF, 1'b1);
        settle();
        write_reg(CFG_SMOOTHING, COEFF_MIN);
        queue_word(16'h5000, 1'b1);
        settle();

        // pair swap: even buffer, then odd buffer with a trailing word
        write_reg(CFG_SMOOTHING, COEFF_RESET);
        write_reg(CFG_SWAP, 16'h0001);
        queue_word(16'h0123, 1'b0);
        queue_word(16'h0456, 1'b1);
        queue_word(16'h0789, 1'b0);
        queue_word(16'h0ABC, 1'b0);
        queue_word(16'h0DEF, 1'b1);
        settle();

        // held word, swap cleared (upper data bits ignored): pair still completes
        queue_word(16'h0321, 1'b0);
        settle();
        write_reg(CFG_SWAP, 16'hFFFE);
        write_reg(CFG_UNMAPPED, 16'h1234);
        queue_word(16'h0654, 1'b1);
        settle();

        // swap enabled mid-buffer: pairing starts with the next word
        queue_word(16'h0111, 1'b0);
        queue_word(16'h0222, 1'b0);
        settle();
        write_reg(CFG_SWAP, 16'h8001);
        queue_word(16'h0333, 1'b0);
        queue_word(16'h0444, 1'b1);
        settle();

        // receiver holds off while a burst arrives: queue fills, input stalls
        no_gaps = 1'b1;
        long_hold_req++;
        queue_buffers(80);
        settle();
        no_gaps = 1'b0;

        // sender goes quiet until all results are drained, then resumes
        queue_buffers(30);
        settle();
        queue_buffers(30);
        settle();

        target_items = items_queued + RANDOM_WORDS;
        while (items_queued < target_items)
        begin
            case ($urandom_range(0, 5))
                0: write_reg(CFG_SMOOTHING, COEFF_MIN);
                1: write_reg(CFG_SMOOTHING, COEFF_MAX);
                2: write_reg(CFG_SMOOTHING, COEFF_RESET);
                3: write_reg(CFG_SMOOTHING, CFG_DATA_W'($urandom_range(1, 255)));
                default: write_reg(CFG_SMOOTHING, CFG_DATA_W'($urandom));
            endcase
            write_reg(CFG_SWAP, CFG_DATA_W'($urandom));
            if ($urandom_range(0, 7) == 0)
                write_reg(CFG_UNMAPPED, CFG_DATA_W'($urandom));
            no_gaps = ($urandom_range(0, 3) == 0);
            queue_buffers($urandom_range(20, 120));
            settle();
        end
        no_gaps = 1'b0;
        settle();

        $display("%0d ADC words sent, %0d register writes, %0d results checked",
                 words_taken, reg_writes, results_seen);
        $display("%0d swapped pairs, %0d saturated samples, %0d mismatches",
                 swapped_pairs, sat_hits, mismatches);
        if (mismatches == 0 && due_samples.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[adc_dc_blocking_conditioner_unit.f]
+incdir+hw/rtl
hw/rtl/dcb_pkg.sv
hw/rtl/dcb_if.sv
hw/rtl/dcb_front.sv
hw/rtl/dcb_queue.sv
hw/rtl/dcb_back.sv
hw/rtl/adc_dc_blocking_conditioner_unit.sv
verif/tb_adc_dc_blocking_conditioner_unit.sv
